// ----- rtl/kdlpr_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlpr_pkg
// Types and constants for the key debouncer with long press and auto repeat.
// ----------------------------------------------------------------------------
package kdlpr_pkg;

    // auto-repeat checks per tick (1..8)
    localparam int REPEAT_CHECKS = 2;

    localparam int HOLD_W     = 10;
    localparam int LIMIT_W    = 8;
    localparam int RCOUNT_W   = 9;
    localparam int KEY_W      = 2;
    localparam int CFG_DATA_W = 10;
    // holds a count of up to eight repeats
    localparam int REPS_CNT_W = 4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_USED_W  = 9;

    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 10'd75;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_SURE = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef enum logic [KEY_W-1:0] {
        KC_NONE  = 2'd0,
        KC_POWER = 2'd1,
        KC_GEAR  = 2'd2
    } key_t;

    typedef enum logic {
        REG_HOLD_TICKS   = 1'b0,
        REG_REPEAT_LIMIT = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/key_debounce_long_press_repeat.sv -----
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat
// Four-phase key debouncer with press, click, long-press and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per scan tick, carrying the raw power
//   and gear key levels. Power wins when both are down.
//   Output stream (m_*): exactly one transaction per input transaction with
//   the phase after the tick and the events raised on that tick.
//   Config port: cfg_we/cfg_index/cfg_wdata write hold_ticks (index 0) or
//   repeat_limit (index 1); write only while no tick is in flight.
// Timing:
//   The result is registered when the tick is accepted. One tick per cycle
//   is sustained while the output is not stalled; the debounce state and the
//   repeat counter update together, the repeat checks being a short chain of
//   REPEAT_CHECKS (two) 9-bit increment/compare steps.
// Reset:
//   aresetn low clears the phase, all flags and counters, empties the output
//   register and restores hold_ticks to 75 and repeat_limit to 10.
// Stall:
//   While a result waits with m_tready low, s_tready is low; the tick that
//   frees the output register may be accepted in the same cycle.
// ----------------------------------------------------------------------------
module key_debounce_long_press_repeat
    import kdlpr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] power_pressed, [1] gear_pressed, [7:2] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] debounce_phase, [2] press_event, [3] click_event, [4] long_event,
    // [6:5] repeat_events, [8:7] event_key, [15:9] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic [HOLD_W-1:0]   hold_ticks_reg;
    logic [LIMIT_W-1:0]  repeat_limit_reg;

    phase_t              phase_reg, phase_next;
    logic [KEY_W-1:0]    previous_key_reg;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic                short_flag_reg, short_flag_next;
    logic                long_flag_reg, long_flag_next;
    logic                click_pending_reg, click_pending_next;
    logic [KEY_W-1:0]    latched_key_reg, latched_key_next;
    logic [RCOUNT_W-1:0] repeat_count_reg, repeat_count_next;

    logic                m_tvalid_reg;
    logic [M_USED_W-1:0] m_data_reg;

    logic [KEY_W-1:0]    key_cur;
    logic                press_ev, click_ev, long_ev;
    logic [1:0]          repeat_ev;
    logic [KEY_W-1:0]    event_key;
    logic                in_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W-M_USED_W){1'b0}}, m_data_reg};

    always_comb begin
        if (s_tdata[0]) begin
            key_cur = KC_POWER;
        end else if (s_tdata[1]) begin
            key_cur = KC_GEAR;
        end else begin
            key_cur = KC_NONE;
        end
    end

    // phase transition and hold counter
    always_comb begin
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        case (phase_reg)
            PH_IDLE: begin
                hold_count_next = '0;
                if (key_cur != KC_NONE) begin
                    phase_next = PH_DOWN;
                end
            end
            PH_DOWN: begin
                phase_next = (previous_key_reg == key_cur) ? PH_SURE : PH_IDLE;
            end
            PH_SURE: begin
                if (key_cur == previous_key_reg) begin
                    if (hold_count_reg < hold_ticks_reg) begin
                        hold_count_next = hold_count_reg + 1'b1;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (key_cur != previous_key_reg) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // flags, repeat counter and events for the phase just entered
    always_comb begin
        logic [RCOUNT_W-1:0]   rc;
        logic [REPS_CNT_W-1:0] reps;
        short_flag_next    = short_flag_reg;
        long_flag_next     = long_flag_reg;
        click_pending_next = click_pending_reg;
        latched_key_next   = latched_key_reg;
        press_ev           = 1'b0;
        click_ev           = 1'b0;
        long_ev            = 1'b0;
        event_key          = KC_NONE;
        rc                 = repeat_count_reg;
        reps               = '0;
        case (phase_next)
            PH_SURE: begin
                if (!short_flag_reg) begin
                    short_flag_next    = 1'b1;
                    click_pending_next = 1'b1;
                    latched_key_next   = key_cur;
                    press_ev           = 1'b1;
                    event_key          = key_cur;
                end
            end
            PH_IDLE: begin
                short_flag_next = 1'b0;
                long_flag_next  = 1'b0;
                rc              = '0;
                if (click_pending_reg) begin
                    click_pending_next = 1'b0;
                    click_ev           = 1'b1;
                    event_key          = latched_key_reg;
                    latched_key_next   = KC_NONE;
                end
            end
            PH_WAIT: begin
                if (!long_flag_reg) begin
                    long_flag_next     = 1'b1;
                    click_pending_next = 1'b0;
                    long_ev            = 1'b1;
                end
                for (int i = 0; i < REPEAT_CHECKS; i++) begin
                    rc = rc + 1'b1;
                    if (rc > {1'b0, repeat_limit_reg}) begin
                        rc   = '0;
                        reps = reps + 1'b1;
                    end
                end
                if (long_ev) begin
                    event_key = key_cur;
                end else if (reps != '0) begin
                    event_key = latched_key_reg;
                end
            end
            default: begin
            end
        endcase
        repeat_count_next = rc;
        repeat_ev = (reps > REPS_CNT_W'(3)) ? 2'd3 : reps[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg   <= HOLD_RESET;
            repeat_limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_wdata[HOLD_W-1:0];
                REG_REPEAT_LIMIT: repeat_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            previous_key_reg  <= KC_NONE;
            hold_count_reg    <= '0;
            short_flag_reg    <= 1'b0;
            long_flag_reg     <= 1'b0;
            click_pending_reg <= 1'b0;
            latched_key_reg   <= KC_NONE;
            repeat_count_reg  <= '0;
        end else if (in_accept) begin
            phase_reg         <= phase_next;
            previous_key_reg  <= key_cur;
            hold_count_reg    <= hold_count_next;
            short_flag_reg    <= short_flag_next;
            long_flag_reg     <= long_flag_next;
            click_pending_reg <= click_pending_next;
            latched_key_reg   <= latched_key_next;
            repeat_count_reg  <= repeat_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {event_key, repeat_ev, long_ev, click_ev, press_ev, phase_next};
        end
    end

endmodule

// ----- rtl/kdlpr_checker.sv -----
// ----------------------------------------------------------------------------
// kdlpr_checker
// Port-level checks of the key debouncer's stream handshake and pipeline.
// ----------------------------------------------------------------------------
module kdlpr_checker
    import kdlpr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // every accepted tick yields a result next cycle
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick produced no result");

    // no tick may be taken while a result is stuck
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("tick accepted while output stalled");

    // a drained result with no new tick leaves the output empty
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result repeated or invented");

    // stalled result holds
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind key_debounce_long_press_repeat kdlpr_checker u_kdlpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key debouncer with long press and auto repeat.
// Feeds scan ticks built from press episodes (contact bounce, short taps,
// holds past the long-press threshold, key swaps) plus raw noise, predicts
// phase and events per tick and compares every output transaction in order.
// Hold and repeat settings are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
    import kdlpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD_OFF = 80;

    typedef struct {
        phase_t     phase;
        bit         press;
        bit         click;
        bit         lng;
        logic [1:0] reps;
        key_t       ekey;
    } tick_events_t;

    // Scoreboard: tracks debouncer state and queues one event record per tick
    class key_event_board;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [LIMIT_W-1:0]  rep_limit;
        phase_t              phase;
        key_t                prev_key;
        key_t                latched_key;
        logic [HOLD_W-1:0]   hold_cnt;
        logic [RCOUNT_W-1:0] rep_cnt;
        bit                  short_seen;
        bit                  long_seen;
        bit                  click_pend;
        tick_events_t        expected_events[$];
        int                  errors;
        int                  checked;
        int                  n_press, n_click, n_long, n_repeat;

        function new();
            hold_ticks  = HOLD_RESET;
            rep_limit   = LIMIT_RESET;
            phase       = PH_IDLE;
            prev_key    = KC_NONE;
            latched_key = KC_NONE;
            hold_cnt    = '0;
            rep_cnt     = '0;
            short_seen  = 0;
            long_seen   = 0;
            click_pend  = 0;
            errors      = 0;
            checked     = 0;
            n_press     = 0;
            n_click     = 0;
            n_long      = 0;
            n_repeat    = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_HOLD_TICKS) begin
                hold_ticks = val[HOLD_W-1:0];
            end else begin
                rep_limit = val[LIMIT_W-1:0];
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_tick(bit pw, bit gr);
            key_t         cur;
            int           reps;
            tick_events_t ev;
            cur      = pw ? KC_POWER : (gr ? KC_GEAR : KC_NONE);
            reps     = 0;
            ev.press = 0;
            ev.click = 0;
            ev.lng   = 0;
            ev.ekey  = KC_NONE;

            case (phase)
                PH_IDLE: begin
                    hold_cnt = '0;
                    if (cur != KC_NONE) phase = PH_DOWN;
                end
                PH_DOWN: phase = (prev_key == cur) ? PH_SURE : PH_IDLE;
                PH_SURE: begin
                    if (cur != prev_key) begin
                        phase = PH_IDLE;
                    end else if (hold_cnt < hold_ticks) begin
                        hold_cnt = hold_cnt + 1'b1;
                    end else begin
                        phase = PH_WAIT;
                    end
                end
                default: begin
                    if (cur != prev_key) begin
                        phase      = PH_IDLE;
                        short_seen = 0;
                        long_seen  = 0;
                    end
                end
            endcase
            prev_key = cur;

            case (phase)
                PH_SURE: begin
                    if (!short_seen) begin
                        short_seen  = 1;
                        click_pend  = 1;
                        latched_key = cur;
                        ev.press    = 1;
                        ev.ekey     = cur;
                    end
                end
                PH_IDLE: begin
                    short_seen = 0;
                    long_seen  = 0;
                    rep_cnt    = '0;
                    if (click_pend) begin
                        click_pend  = 0;
                        ev.click    = 1;
                        ev.ekey     = latched_key;
                        latched_key = KC_NONE;
                    end
                end
                PH_WAIT: begin
                    if (!long_seen) begin
                        long_seen  = 1;
                        click_pend = 0;
                        ev.lng     = 1;
                    end
                    for (int i = 0; i < REPEAT_CHECKS; i++) begin
                        rep_cnt = rep_cnt + 1'b1;
                        if (rep_cnt > {1'b0, rep_limit}) begin
                            rep_cnt = '0;
                            reps++;
                        end
                    end
                    if (ev.lng) begin
                        ev.ekey = cur;
                    end else if (reps != 0) begin
                        ev.ekey = latched_key;
                    end
                end
                default: ;
            endcase

            if (reps > 3) reps = 3;
            ev.phase = phase;
            ev.reps  = reps[1:0];
            n_press  += ev.press;
            n_click  += ev.click;
            n_long   += ev.lng;
            n_repeat += reps;
            expected_events.push_back(ev);
        endfunction

        task report(string field, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] MISMATCH result %0d %s: got %0h want %0h",
                         $time, checked, field, got, want);
            end
        endtask

        task check_result(logic [M_TDATA_W-1:0] d);
            tick_events_t ev;
            if (expected_events.size() == 0) begin
                report("unexpected transaction", d, '0);
                return;
            end
            ev = expected_events.pop_front();
            if (d[1:0] !== ev.phase)  report("debounce_phase", d[1:0], ev.phase);
            if (d[2] !== ev.press)    report("press_event", d[2], ev.press);
            if (d[3] !== ev.click)    report("click_event", d[3], ev.click);
            if (d[4] !== ev.lng)      report("long_event", d[4], ev.lng);
            if (d[6:5] !== ev.reps)   report("repeat_events", d[6:5], ev.reps);
            if (d[8:7] !== ev.ekey)   report("event_key", d[8:7], ev.ekey);
            if (d[15:9] !== 7'd0)     report("padding", d[15:9], '0);
            checked++;
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    key_event_board board;
    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  sink_hold_req = 0;
    int  sink_hold_left = 0;
    int  ticks_sent    = 0;
    int  cycles        = 0;

    key_debounce_long_press_repeat u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, board.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: ready pattern set on falling edges, long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                sink_hold_req  = 0;
                sink_hold_left = LONG_HOLD_OFF;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    task automatic send_tick(bit pw, bit gr);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, gr, pw};
        do @(posedge aclk); while (!s_tready);
        board.note_tick(pw, gr);
        ticks_sent++;
    endtask

    task automatic send_key(bit pw, bit gr, int n);
        repeat (n) send_tick(pw, gr);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] lim);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_REPEAT_LIMIT, lim);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // stop offering, then wait for every expected transaction plus a margin
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin src_idle_pct = 31; sink_idle_pct = 82; end
            1: begin src_idle_pct = 82; sink_idle_pct = 31; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
        endcase
    endtask

    task automatic play_episode();
        int hold;
        int lim;
        int k;
        int n;
        bit pw;
        bit gr;
        hold = board.hold_ticks;
        lim  = board.rep_limit;
        if ($urandom_range(0, 9) < 2) begin
            // raw noise on both lines
            repeat ($urandom_range(1, 6))
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            return;
        end
        k  = $urandom_range(0, 2);
        pw = (k != 1);
        gr = (k != 0);
        repeat ($urandom_range(0, 2)) begin
            send_tick(pw, gr);
            send_tick(0, 0);
        end
        case ($urandom_range(0, 2))
            0: n = $urandom_range(1, 3);
            1: n = hold + $urandom_range(0, 4);
            default: n = hold + 3 + $urandom_range(0, 2 * lim + 8);
        endcase
        if (n > 80) n = $urandom_range(1, 40);
        if (k == 2 && $urandom_range(0, 3) == 0) begin
            // power let go first, gear stays down: key change mid-press
            send_key(1, 1, n / 2 + 1);
            send_key(0, 1, n / 2 + 1);
        end else begin
            send_key(pw, gr, n);
        end
        send_key(0, 0, $urandom_range(1, 3));
    endtask

    initial begin
        int target;
        logic [CFG_DATA_W-1:0] hold;
        logic [CFG_DATA_W-1:0] lim;
        board = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: long press with repeats, then a short gear tap
        set_idle(0);
        send_key(1, 0, 100);
        send_key(0, 0, 3);
        send_key(0, 1, 5);
        send_key(0, 0, 3);
        drain();

        // zero hold, zero limit: every check fires
        configure(10'd0, 10'd0);
        send_tick(0, 0);
        send_key(1, 1, 2);         // both down, power wins, press
        send_key(1, 0, 2);         // same key: long at once, then repeats
        send_key(0, 1, 3);         // change while waiting: idle, no click
        send_tick(1, 0);           // change while confirmed: click on gear
        send_tick(0, 0);
        send_tick(0, 1);
        send_tick(0, 0);           // down seen then released
        send_key(0, 1, 4);
        send_key(0, 0, 2);
        drain();

        // largest hold, largest limit; upper data bits must be dropped
        set_idle(1);
        configure(10'd1023, 10'h3FF);
        send_key(0, 1, 40);
        send_key(0, 0, 2);
        send_key(1, 0, 6);
        send_key(0, 0, 2);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    hold = CFG_DATA_W'($urandom_range(0, 6));
                    lim  = '0;
                end
                1: begin
                    hold = '0;
                    lim  = CFG_DATA_W'($urandom_range(1, 5) | ($urandom_range(0, 3) << 8));
                end
                2: begin
                    hold = CFG_DATA_W'($urandom_range(0, 10));
                    lim  = CFG_DATA_W'(255);
                end
                3: begin
                    hold = CFG_DATA_W'($urandom_range(0, 12));
                    lim  = CFG_DATA_W'($urandom_range(0, 8));
                end
                4: begin
                    hold = CFG_DATA_W'(1023);
                    lim  = CFG_DATA_W'($urandom_range(0, 255));
                end
                default: begin
                    hold = CFG_DATA_W'($urandom_range(0, 20));
                    lim  = CFG_DATA_W'($urandom_range(0, 20));
                end
            endcase
            configure(hold, lim);
            set_idle(ph % 3);
            if (ph == 3) sink_hold_req = 1;
            target = ticks_sent + 40;
            while (ticks_sent < target) play_episode();
            drain();
        end

        repeat (10) @(posedge aclk);
        $display("Sent %0d scan ticks over nine settings, %0d results checked",
                 ticks_sent, board.checked);
        $display("Events seen: %0d press, %0d click, %0d long, %0d repeat",
                 board.n_press, board.n_click, board.n_long, board.n_repeat);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", board.errors, board.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kdlpr_pkg.sv
rtl/key_debounce_long_press_repeat.sv
rtl/kdlpr_checker.sv
bench/testbench.sv
